// File: hw/rtl/rsaw_pkg.sv
package rsaw_pkg;

  localparam int SEQ_W  = 16;
  localparam int MODE_W = 2;
  localparam int SLOT_W = 4;
  localparam int CFG_IDX_W = 2;

  typedef logic [SEQ_W-1:0] seq_t;

  // Input mode codes
  localparam logic [MODE_W-1:0] MODE_SEND    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ACK     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_INBOUND = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RETRY     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEEPALIVE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONNECTED = 2'd3;

  localparam seq_t RETRY_RESET     = 16'd640;
  localparam seq_t KEEPALIVE_RESET = 16'd1600;
  localparam seq_t TIMEOUT_RESET   = 16'd16000;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_SEND,
    OP_ACK,
    OP_TICK,
    OP_INBOUND
  } op_e;

  typedef struct packed {
    op_e  op;
    seq_t ack_seq;
  } item_t;

  typedef struct packed {
    seq_t retry_ticks;
    seq_t keepalive_ticks;
    seq_t timeout_ticks;
    logic connected_enable;
  } cfg_t;

  typedef enum logic {
    ST_IDLE,
    ST_SLIDE
  } back_state_e;

endpackage

// File: hw/rtl/rsaw_in_if.sv
interface rsaw_in_if;
  logic                       valid;
  logic                       ready;
  logic [rsaw_pkg::MODE_W-1:0] mode;
  rsaw_pkg::seq_t             ack_seq;

  modport source (output valid, output mode, output ack_seq, input ready);
  modport sink   (input valid, input mode, input ack_seq, output ready);
endinterface

// File: hw/rtl/rsaw_out_if.sv
interface rsaw_out_if;
  logic                        valid;
  logic                        ready;
  logic                        accepted;
  logic [rsaw_pkg::SLOT_W-1:0] slot_index;
  rsaw_pkg::seq_t              assigned_seq;
  logic                        retransmit_head;
  logic                        keepalive_due;
  logic                        link_dead;
  logic                        in_sync;
  rsaw_pkg::seq_t              base_sequence;

  modport source (output valid, output accepted, output slot_index, output assigned_seq,
                  output retransmit_head, output keepalive_due, output link_dead,
                  output in_sync, output base_sequence, input ready);
  modport sink   (input valid, input accepted, input slot_index, input assigned_seq,
                  input retransmit_head, input keepalive_due, input link_dead,
                  input in_sync, input base_sequence, output ready);
endinterface

// File: hw/rtl/reliable_send_ack_window.sv
// Sender-side selective-repeat window with 16-bit wrapping sequence numbers.
//
// Channels: in_i carries one item per transfer (mode, ack_seq); out_o returns
// exactly one result per item, in order. Both use valid/ready; a transfer
// happens on a rising edge with valid and ready high.
// Config: cfg_we_i writes cfg_data_i into register cfg_idx_i (0 retry,
// 1 keep-alive, 2 timeout, 3 connected enable). Write only when idle.
//
// Flow: send, tick and other-inbound items register their result on out_o
// and flow at one per cycle while the receiver takes results and no ack is
// sliding. An ack holds the back end while the base slides over k cleared
// head slots, where k <= WINDOW_SLOTS, one slot per cycle in the shift of
// the pending vector; its result is registered once the slide ends.
// A two-entry queue sits between the decode front and the back end.
//
// Reset clears the sequence state, pending bits, timers and queue, and loads
// the register defaults (640, 1600, 16000, off); no clearing pass is needed.
// When the receiver stalls, the result holds in the output register, the back
// end stops, and in_i keeps taking items until the queue fills.
module reliable_send_ack_window #(
  parameter int WINDOW_SLOTS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  rsaw_in_if.sink                        in_i,
  rsaw_out_if.source                     out_o,
  input  logic                           cfg_we_i,
  input  logic [rsaw_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  rsaw_pkg::seq_t                 cfg_data_i
);
  import rsaw_pkg::*;

  cfg_t  cfg_q;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.retry_ticks      <= RETRY_RESET;
      cfg_q.keepalive_ticks  <= KEEPALIVE_RESET;
      cfg_q.timeout_ticks    <= TIMEOUT_RESET;
      cfg_q.connected_enable <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RETRY:     cfg_q.retry_ticks      <= cfg_data_i;
        REG_KEEPALIVE: cfg_q.keepalive_ticks  <= cfg_data_i;
        REG_TIMEOUT:   cfg_q.timeout_ticks    <= cfg_data_i;
        REG_CONNECTED: cfg_q.connected_enable <= cfg_data_i[0];
        default:       cfg_q <= cfg_q;
      endcase
    end
  end

  // front: decode mode and buffer items
  rsaw_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  // back: window state, timers, result register
  rsaw_back #(
    .WINDOW_SLOTS (WINDOW_SLOTS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule

// File: hw/rtl/rsaw_front.sv
module rsaw_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  rsaw_in_if.sink         in_i,
  output logic            q_valid_o,
  output rsaw_pkg::item_t q_item_o,
  input  logic            q_pop_i
);
  import rsaw_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              push, pop;
  item_t             item_in;

  // classify the incoming mode
  always_comb begin
    item_in.ack_seq = in_i.ack_seq;
    case (in_i.mode)
      MODE_SEND:    item_in.op = OP_SEND;
      MODE_ACK:     item_in.op = OP_ACK;
      MODE_TICK:    item_in.op = OP_TICK;
      default:      item_in.op = OP_INBOUND;
    endcase
  end

  assign in_i.ready = (count_q != CNT_W'(QUEUE_DEPTH));
  assign push       = in_i.valid && in_i.ready;
  assign q_valid_o  = (count_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

// File: hw/rtl/rsaw_back.sv
module rsaw_back #(
  parameter int WINDOW_SLOTS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rsaw_pkg::cfg_t  cfg_i,
  input  logic            q_valid_i,
  input  rsaw_pkg::item_t q_item_i,
  output logic            q_pop_o,
  rsaw_out_if.source      out_o
);
  import rsaw_pkg::*;

  localparam int   IDX_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam seq_t WS    = SEQ_W'(WINDOW_SLOTS);

  function automatic seq_t sat_inc(input seq_t v);
    sat_inc = (v == '1) ? v : v + 1'b1;
  endfunction

  back_state_e              state_q, state_d;
  seq_t                     next_q, next_d;
  seq_t                     base_q, base_d;
  seq_t                     latest_q, latest_d;
  logic [WINDOW_SLOTS-1:0]  pending_q, pending_d;
  seq_t                     t_send_q, t_send_d;
  seq_t                     t_inb_q, t_inb_d;
  seq_t                     t_keep_q, t_keep_d;

  logic                     out_valid_q, out_valid_d;
  logic                     acc_q, acc_d;
  logic [SLOT_W-1:0]        slot_q, slot_d;
  seq_t                     seq_q, seq_d;
  logic                     retx_q, retx_d;
  logic                     keep_q, keep_d;
  logic                     dead_q, dead_d;
  logic                     sync_q, sync_d;
  seq_t                     obase_q, obase_d;

  seq_t send_off, ack_lat_off, ack_base_off, lat_base_off;
  seq_t inc_send, inc_inb, inc_keep;
  logic sync, slide_go, out_free;

  assign send_off     = next_q - base_q;
  assign ack_lat_off  = q_item_i.ack_seq - latest_q;
  assign ack_base_off = q_item_i.ack_seq - base_q;
  assign lat_base_off = latest_q - base_q;
  assign sync         = ((base_q - latest_q) == 16'd1);
  assign slide_go     = !pending_q[0] && (lat_base_off < WS) && (base_q != next_q);
  assign out_free     = !out_valid_q || out_o.ready;
  assign inc_send     = sat_inc(t_send_q);
  assign inc_inb      = sat_inc(t_inb_q);
  assign inc_keep     = sat_inc(t_keep_q);

  always_comb begin
    state_d     = state_q;
    next_d      = next_q;
    base_d      = base_q;
    latest_d    = latest_q;
    pending_d   = pending_q;
    t_send_d    = t_send_q;
    t_inb_d     = t_inb_q;
    t_keep_d    = t_keep_q;
    out_valid_d = out_valid_q && !out_o.ready;
    acc_d       = acc_q;
    slot_d      = slot_q;
    seq_d       = seq_q;
    retx_d      = retx_q;
    keep_d      = keep_q;
    dead_d      = dead_q;
    sync_d      = sync_q;
    obase_d     = obase_q;
    q_pop_o     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          acc_d   = 1'b0;
          slot_d  = '0;
          seq_d   = '0;
          retx_d  = 1'b0;
          keep_d  = 1'b0;
          dead_d  = 1'b0;
          sync_d  = sync;
          obase_d = base_q;
          case (q_item_i.op)
            OP_SEND: begin
              out_valid_d = 1'b1;
              if (send_off < WS) begin
                pending_d[send_off[IDX_W-1:0]] = 1'b1;
                acc_d  = 1'b1;
                slot_d = send_off[SLOT_W-1:0];
                seq_d  = next_q;
                next_d = next_q + 1'b1;
                if (sync) begin
                  t_send_d = '0;
                end
              end
            end
            OP_ACK: begin
              // result goes out once the base has slid
              if (ack_lat_off < WS) begin
                latest_d = q_item_i.ack_seq;
              end
              if (ack_base_off < WS) begin
                pending_d[ack_base_off[IDX_W-1:0]] = 1'b0;
              end
              t_inb_d = '0;
              state_d = ST_SLIDE;
            end
            OP_TICK: begin
              out_valid_d = 1'b1;
              t_send_d    = inc_send;
              t_inb_d     = inc_inb;
              t_keep_d    = inc_keep;
              if (cfg_i.connected_enable) begin
                dead_d = (inc_inb >= cfg_i.timeout_ticks);
                if (inc_keep > cfg_i.keepalive_ticks) begin
                  keep_d   = 1'b1;
                  t_keep_d = '0;
                end
              end
              if (pending_q[0] && (inc_send > cfg_i.retry_ticks)) begin
                retx_d   = 1'b1;
                t_send_d = '0;
              end
            end
            default: begin
              out_valid_d = 1'b1;
              t_inb_d     = '0;
            end
          endcase
        end
      end
      ST_SLIDE: begin
        if (slide_go) begin
          pending_d = {1'b0, pending_q[WINDOW_SLOTS-1:1]};
          base_d    = base_q + 1'b1;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          sync_d      = sync;
          obase_d     = base_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      next_q      <= '0;
      base_q      <= '0;
      latest_q    <= '0;
      pending_q   <= '0;
      t_send_q    <= '0;
      t_inb_q     <= '0;
      t_keep_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_q      <= next_d;
      base_q      <= base_d;
      latest_q    <= latest_d;
      pending_q   <= pending_d;
      t_send_q    <= t_send_d;
      t_inb_q     <= t_inb_d;
      t_keep_q    <= t_keep_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    slot_q  <= slot_d;
    seq_q   <= seq_d;
    retx_q  <= retx_d;
    keep_q  <= keep_d;
    dead_q  <= dead_d;
    sync_q  <= sync_d;
    obase_q <= obase_d;
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.accepted        = acc_q;
  assign out_o.slot_index      = slot_q;
  assign out_o.assigned_seq    = seq_q;
  assign out_o.retransmit_head = retx_q;
  assign out_o.keepalive_due   = keep_q;
  assign out_o.link_dead       = dead_q;
  assign out_o.in_sync         = sync_q;
  assign out_o.base_sequence   = obase_q;

  // base never runs past the packets sent
  a_base_behind_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_q - base_q) <= WS)
    else $error("window base passed next sequence");

  // the output register is empty while sliding
  a_slide_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SLIDE) |-> !out_valid_q)
    else $error("result pending during slide");

  // each slide step moves the base by exactly one
  a_slide_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SLIDE && slide_go) |=> (base_q == $past(base_q) + 16'd1))
    else $error("slide step lost");

  // no item is taken from the queue while sliding
  a_no_pop_in_slide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SLIDE) |-> !q_pop_o)
    else $error("queue popped during slide");

endmodule

// File: tb/sv/testbench.sv
module testbench;
  import rsaw_pkg::*;

  // Window depth must match the parameter given to the block below.
  localparam int      WIN_SLOTS   = 16;
  // Worst ack: the pipe plus a full-window slide, with margin.
  localparam int      DRAIN_WAIT  = 2 + WIN_SLOTS + 4;
  // About 1900 items; take the worst case of each, an ack sliding a full
  // window under the longest gap and stall, several times over.
  localparam longint  CYCLE_LIMIT = 64'd500_000;
  localparam int      MAX_REPORTS = 50;

  // Sender-side view of the window. Both the live copy (advanced on each
  // input transfer) and the planning copy (advanced as stimulus is queued)
  // use this shape.
  typedef struct packed {
    seq_t                 next_seq;
    seq_t                 base;
    seq_t                 last_ack;
    logic [WIN_SLOTS-1:0] pend;     // bit k: packet base+k not yet acked
    seq_t                 t_send;
    seq_t                 t_in;
    seq_t                 t_keep;
  } send_window_t;

  typedef struct packed {
    logic              accepted;
    logic [SLOT_W-1:0] slot_index;
    seq_t              assigned_seq;
    logic              retransmit_head;
    logic              keepalive_due;
    logic              link_dead;
    logic              in_sync;
    seq_t              base_sequence;
  } window_result_t;

  logic clk_i;
  logic rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  seq_t                 cfg_data_i;

  rsaw_in_if  item_ch ();
  rsaw_out_if result_ch ();

  reliable_send_ack_window #(
    .WINDOW_SLOTS(WIN_SLOTS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (item_ch),
    .out_o      (result_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Register shadow; only changed while the block is idle.
  seq_t retry_lim;
  seq_t keep_lim;
  seq_t silence_lim;
  logic link_watch;

  send_window_t   live_win;          // advanced on input transfers
  send_window_t   plan_win;          // advanced as items are queued
  item_t          item_backlog[$];   // items not yet offered
  window_result_t awaited_results[$];

  item_t          cur_item;
  window_result_t want;
  int             send_gap;
  int             stall_left;
  bit             idling;
  int             mismatch_count;
  int             results_seen;
  longint         cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // One item through the window. Returns what the block must report and
  // updates st in place. Fields that do not apply to the mode stay zero.
  function automatic window_result_t window_step(inout send_window_t st, input item_t it);
    window_result_t r;
    seq_t           d;
    r = '0;
    case (it.op)
      OP_SEND: begin
        d = st.next_seq - st.base;
        // full window: refused, nothing moves
        if (d < WIN_SLOTS) begin
          st.pend[d[SLOT_W-1:0]] = 1'b1;
          r.accepted     = 1'b1;
          r.slot_index   = d[SLOT_W-1:0];
          r.assigned_seq = st.next_seq;
          st.next_seq    = st.next_seq + 1'b1;
          // retry timer restarts only if everything was acked before this send
          d = st.base - st.last_ack;
          if (d == 16'd1) st.t_send = '0;
        end
      end
      OP_ACK: begin
        d = it.ack_seq - st.last_ack;
        if (d < WIN_SLOTS) st.last_ack = it.ack_seq;
        d = it.ack_seq - st.base;
        if (d < WIN_SLOTS) st.pend[d[SLOT_W-1:0]] = 1'b0;
        // slide over cleared head slots, never past what was sent
        d = st.last_ack - st.base;
        while (!st.pend[0] && d < WIN_SLOTS && st.base != st.next_seq) begin
          st.pend = st.pend >> 1;
          st.base = st.base + 1'b1;
          d       = st.last_ack - st.base;
        end
        st.t_in = '0;
      end
      OP_TICK: begin
        if (st.t_send != '1) st.t_send = st.t_send + 1'b1;
        if (st.t_in   != '1) st.t_in   = st.t_in + 1'b1;
        if (st.t_keep != '1) st.t_keep = st.t_keep + 1'b1;
        if (link_watch) begin
          if (st.t_in >= silence_lim) r.link_dead = 1'b1;
          if (st.t_keep > keep_lim) begin
            r.keepalive_due = 1'b1;
            st.t_keep       = '0;
          end
        end
        if (st.pend[0] && st.t_send > retry_lim) begin
          r.retransmit_head = 1'b1;
          st.t_send         = '0;
        end
      end
      default: begin
        st.t_in = '0;
      end
    endcase
    d               = st.base - st.last_ack;
    r.in_sync       = (d == 16'd1);
    r.base_sequence = st.base;
    return r;
  endfunction

  function automatic window_result_t queue_item(input op_e op, input seq_t ack);
    item_t it;
    it.op      = op;
    it.ack_seq = ack;
    item_backlog.push_back(it);
    return window_step(plan_win, it);
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch on result %0d: %s", results_seen, what);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input seq_t value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_RETRY:     retry_lim   = value;
      REG_KEEPALIVE: keep_lim    = value;
      REG_TIMEOUT:   silence_lim = value;
      REG_CONNECTED: link_watch  = value[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input seq_t retry, input seq_t keep, input seq_t silence,
                            input logic conn);
    seq_t cdata;
    cdata    = $urandom;  // upper bits are don't-care for the enable
    cdata[0] = conn;
    write_reg(REG_RETRY, retry);
    write_reg(REG_KEEPALIVE, keep);
    write_reg(REG_TIMEOUT, silence);
    write_reg(REG_CONNECTED, cdata);
  endtask

  // Sender holds off until every outstanding result is back, then lets the
  // longest ack slide finish before anything else happens.
  task automatic wait_window_drained();
    do @(negedge clk_i);
    while (item_backlog.size() != 0 || item_ch.valid || awaited_results.size() != 0);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  // Mostly well-formed traffic: sends, acks of outstanding packets (head
  // ack weighted so the base keeps sliding), ticks and inbound activity,
  // plus stale, near-window and fully random acks as noise.
  task automatic gen_traffic(input int n);
    item_t          it;
    send_window_t   trial;
    window_result_t dummy;
    seq_t           span;
    seq_t           d;
    int             pick;
    for (int i = 0; i < n; i++) begin
      span       = plan_win.next_seq - plan_win.base;
      pick       = $urandom_range(0, 99);
      it.ack_seq = $urandom;
      if (pick < 30) begin
        it.op = OP_SEND;
      end else if (pick < 62) begin
        it.op = OP_ACK;
        if (span == 0)
          it.ack_seq = plan_win.last_ack - 16'd2 + 16'($urandom_range(0, 4));
        else if ($urandom_range(0, 9) < 4)
          it.ack_seq = plan_win.base;
        else
          it.ack_seq = plan_win.base + 16'($urandom_range(0, span - 1));
      end else if (pick < 70) begin
        it.op      = OP_ACK;
        it.ack_seq = plan_win.base - 16'd8 + 16'($urandom_range(0, 31));
      end else if (pick < 74) begin
        it.op = OP_ACK;
      end else if (pick < 92) begin
        it.op = OP_TICK;
      end else begin
        it.op = OP_INBOUND;
      end
      // An ack that drags the latest-ack mark a full window past the base
      // would freeze the window for good; swap it for a tick.
      trial = plan_win;
      dummy = window_step(trial, it);
      d     = trial.last_ack - trial.base;
      if (it.op == OP_ACK && d >= WIN_SLOTS && d != 16'hFFFF) it.op = OP_TICK;
      dummy = queue_item(it.op, it.ack_seq);
    end
  endtask

  // Two rounds: fill the window (sends past a full window are refused), then
  // ack everything outstanding in shuffled order.
  task automatic fill_window_rounds();
    seq_t           outstanding[$];
    seq_t           span;
    seq_t           tmp;
    window_result_t r;
    int             j;
    for (int round = 0; round < 2; round++) begin
      repeat (WIN_SLOTS) begin
        r = queue_item(OP_SEND, seq_t'($urandom));
      end
      outstanding.delete();
      span = plan_win.next_seq - plan_win.base;
      for (int k = 0; k < span; k++) outstanding.push_back(plan_win.base + seq_t'(k));
      for (int k = outstanding.size() - 1; k > 0; k--) begin
        j              = $urandom_range(0, k);
        tmp            = outstanding[k];
        outstanding[k] = outstanding[j];
        outstanding[j] = tmp;
      end
      foreach (outstanding[k]) r = queue_item(OP_ACK, outstanding[k]);
    end
  endtask

  // Driver: offers queued items, with random gaps while idling is on. The
  // expected result is computed at the transfer edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (item_ch.valid && item_ch.ready)
        awaited_results.push_back(window_step(live_win, cur_item));
      if (!item_ch.valid || item_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          item_ch.valid <= 1'b0;
        end else if (item_backlog.size() > 0) begin
          cur_item         = item_backlog.pop_front();
          item_ch.valid   <= 1'b1;
          item_ch.mode    <= cur_item.op;
          item_ch.ack_seq <= cur_item.ack_seq;
          if (idling && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 5);
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result transfer is checked against the oldest
  // expectation; ready drops in random bursts while idling is on.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_ch.valid && result_ch.ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result with nothing outstanding");
        end else begin
          want = awaited_results.pop_front();
          if (result_ch.accepted !== want.accepted)
            report_mismatch($sformatf("accepted %0b, want %0b",
                                      result_ch.accepted, want.accepted));
          if (result_ch.slot_index !== want.slot_index)
            report_mismatch($sformatf("slot_index %0d, want %0d",
                                      result_ch.slot_index, want.slot_index));
          if (result_ch.assigned_seq !== want.assigned_seq)
            report_mismatch($sformatf("assigned_seq %0d, want %0d",
                                      result_ch.assigned_seq, want.assigned_seq));
          if (result_ch.retransmit_head !== want.retransmit_head)
            report_mismatch($sformatf("retransmit_head %0b, want %0b",
                                      result_ch.retransmit_head, want.retransmit_head));
          if (result_ch.keepalive_due !== want.keepalive_due)
            report_mismatch($sformatf("keepalive_due %0b, want %0b",
                                      result_ch.keepalive_due, want.keepalive_due));
          if (result_ch.link_dead !== want.link_dead)
            report_mismatch($sformatf("link_dead %0b, want %0b",
                                      result_ch.link_dead, want.link_dead));
          if (result_ch.in_sync !== want.in_sync)
            report_mismatch($sformatf("in_sync %0b, want %0b",
                                      result_ch.in_sync, want.in_sync));
          if (result_ch.base_sequence !== want.base_sequence)
            report_mismatch($sformatf("base_sequence %0d, want %0d",
                                      result_ch.base_sequence, want.base_sequence));
        end
        results_seen++;
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
        if (idling && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 5);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    window_result_t dummy;
    // known levels on every input from time zero
    rst_ni          = 1'b0;
    item_ch.valid   = 1'b0;
    item_ch.mode    = OP_SEND;
    item_ch.ack_seq = '0;
    result_ch.ready = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = REG_RETRY;
    cfg_data_i      = '0;
    retry_lim       = RETRY_RESET;
    keep_lim        = KEEPALIVE_RESET;
    silence_lim     = TIMEOUT_RESET;
    link_watch      = 1'b0;
    live_win        = '0;
    plan_win        = '0;
    send_gap        = 0;
    stall_left      = 0;
    idling          = 1'b1;
    mismatch_count  = 0;
    results_seen    = 0;
    cycle_count     = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset register values.
    // Ack far outside the window before anything was sent.
    dummy = queue_item(OP_ACK, 16'hFFFF);
    // 16 sends fill the window, the 17th is refused.
    repeat (WIN_SLOTS + 1) dummy = queue_item(OP_SEND, 16'h0000);
    // selective ack ahead of the head: no slide
    dummy = queue_item(OP_ACK, 16'd3);
    // head ack behind the latest mark: clears, slides by one
    dummy = queue_item(OP_ACK, 16'd0);
    // beyond the window: ignored
    dummy = queue_item(OP_ACK, 16'd20);
    dummy = queue_item(OP_ACK, 16'd1);
    // slides over 2 and the already cleared 3
    dummy = queue_item(OP_ACK, 16'd2);
    dummy = queue_item(OP_SEND, 16'hFFFF);
    dummy = queue_item(OP_TICK, 16'hA5A5);
    dummy = queue_item(OP_INBOUND, 16'h5A5A);

    // Random traffic under several register settings.
    wait_window_drained();
    set_config(16'd4, 16'd6, 16'd12, 1'b1);
    gen_traffic(300);

    // minimum register values, no idling on either side
    wait_window_drained();
    idling = 1'b0;
    set_config(16'd1, 16'd1, 16'd1, 1'b1);
    gen_traffic(200);

    // zero timers fire on every tick (retransmit only while the head is pending)
    wait_window_drained();
    idling = 1'b1;
    set_config(16'd0, 16'd0, 16'd0, 1'b1);
    gen_traffic(100);

    // connection checks off: only the retransmit timer acts
    wait_window_drained();
    set_config(16'd20, 16'd9, 16'd30, 1'b0);
    gen_traffic(300);

    repeat (6) begin
      wait_window_drained();
      idling = ($urandom_range(0, 3) != 0);
      set_config(seq_t'($urandom_range(1, 40)), seq_t'($urandom_range(1, 40)),
                 seq_t'($urandom_range(1, 60)), 1'($urandom_range(0, 1)));
      gen_traffic(150);
    end

    // Closing stretch runs without idling.
    // Full-window fills, each drained by shuffled acks.
    wait_window_drained();
    idling = 1'b0;
    set_config(16'd50, 16'd100, 16'd200, 1'b0);
    fill_window_rounds();

    // Top-of-range registers: a short run of ticks stays below every limit.
    wait_window_drained();
    set_config(16'hFFFE, 16'hFFFF, 16'hFFFF, 1'b1);
    dummy = queue_item(OP_SEND, 16'h0000);
    repeat (8) dummy = queue_item(OP_TICK, seq_t'($urandom));

    wait_window_drained();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
